@@ hw/rtl/tlpd_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpd_pkg
// Types and constants shared by the two-level priority dispatcher.
// ----------------------------------------------------------------------------
package tlpd_pkg;

  typedef enum logic [1:0] {
    REQ_NORMAL = 2'd0,
    REQ_URGENT = 2'd1,
    REQ_TAKE   = 2'd2,
    REQ_RSVD   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_HEAP = 2'd1,
    SRC_FIFO = 2'd2
  } source_t;

  localparam logic [3:0] NORMAL_URGENCY = 4'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  urgency;
    logic [15:0] payload_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  source;
    logic [3:0]  out_urgency;
    logic [15:0] out_tag;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIFO_RD,
    S_FIFO_WAIT,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_POP_RD,
    S_POP_WAIT,
    S_POP_ROOT,
    S_DN_RD,
    S_DN_WAIT,
    S_DN_CMP,
    S_DONE
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_req;
    logic fifo_push;
    logic fifo_rd;
    logic fifo_pop;
    logic up_start;
    logic up_rd;
    logic up_step;
    logic pop_rd;
    logic pop_root;
    logic dn_rd;
    logic dn_step;
    logic set_full;
    logic set_empty;
    logic set_ok;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic fifo_full;
    logic fifo_empty;
    logic heap_full;
    logic heap_empty;
    logic up_done;
    logic dn_done;
  } stat_t;

endpackage

@@ hw/rtl/two_level_priority_dispatcher_top.sv @@
// ----------------------------------------------------------------------------
// two_level_priority_dispatcher_top
// Urgent items in a binary max-heap, normal items in a circular FIFO.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) carries one request: add normal,
// add urgent, or take next. Each request gives exactly one result on the
// output channel (out_valid/out_stall/out_data).
// One request is handled at a time; in_stall is high from acceptance until
// the result is taken. A heap insert climbs and a heap take descends at most
// log2(HEAP_DEPTH) levels; each sift step waits on the registered heap RAM
// read data.
// Reset clears the counters and pointers; storage contents are not cleared.
// If out_stall is high the result stays on out_data and no new request
// is taken until it goes low.
// ----------------------------------------------------------------------------
module two_level_priority_dispatcher_top #(
  parameter int HEAP_DEPTH = 64,
  parameter int FIFO_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlpd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tlpd_pkg::out_item_t out_data
);
  import tlpd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tlpd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_req(in_data.req_type),
    .out_valid, .out_stall, .stat, .cmd
  );

  tlpd_datapath #(.HEAP_DEPTH(HEAP_DEPTH), .FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .res(out_data)
  );

endmodule

@@ hw/rtl/tlpd_ram.sv @@
// ----------------------------------------------------------------------------
// tlpd_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hw/rtl/tlpd_datapath.sv @@
// ----------------------------------------------------------------------------
// tlpd_datapath
// Heap and FIFO storage, counters, sift index and result register.
// ----------------------------------------------------------------------------
module tlpd_datapath #(
  parameter int HEAP_DEPTH = 64,
  parameter int FIFO_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  tlpd_pkg::in_item_t  in_item,
  input  tlpd_pkg::cmd_t      cmd,
  output tlpd_pkg::stat_t     stat,
  output tlpd_pkg::out_item_t res
);
  import tlpd_pkg::*;

  localparam int HAW = $clog2(HEAP_DEPTH);
  localparam int HIW = $clog2(HEAP_DEPTH + 1);   // 1-based index / count
  localparam int FAW = $clog2(FIFO_DEPTH);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);
  localparam int HEW = 20;                        // key + tag

  in_item_t          req;
  logic [HIW-1:0]    heap_count;
  logic [HIW:0]      idx;        // current 1-based position, one spare bit
  logic [HEW-1:0]    cur;        // entry being sifted
  logic [FAW-1:0]    fifo_head, fifo_tail;
  logic [FCW-1:0]    fifo_count;

  // heap ram
  logic            h_we;
  logic [HAW-1:0]  h_waddr, h_ra, h_rb;
  logic [HEW-1:0]  h_wdata, h_qa, h_qb;
  // fifo ram
  logic [15:0]     f_qa, f_qb;

  logic [HIW:0]    parent, lchild, rchild;
  logic            l_ok, r_ok, l_big, r_big;
  logic [HIW:0]    big_idx;
  logic [HEW-1:0]  big_ent;

  assign parent = idx >> 1;
  assign lchild = {idx[HIW-1:0], 1'b0};
  assign rchild = {idx[HIW-1:0], 1'b1};

  // read ports: a = parent, left child or root, b = right child or last entry
  always_comb begin
    h_ra = '0;
    h_rb = '0;
    if (cmd.up_rd) begin
      h_ra = HAW'(parent - 1'b1);
    end else if (cmd.dn_rd) begin
      h_ra = HAW'(lchild - 1'b1);
      h_rb = HAW'(rchild - 1'b1);
    end else if (cmd.pop_rd) begin
      h_ra = '0;
      h_rb = HAW'(heap_count - 1'b1);
    end
  end

  // sift-down choice, left first, strict compares
  assign l_ok  = lchild <= (HIW+1)'(heap_count);
  assign r_ok  = rchild <= (HIW+1)'(heap_count);
  assign l_big = l_ok && (h_qa[19:16] > cur[19:16]);
  always_comb begin
    big_idx = idx;
    big_ent = cur;
    if (l_big) begin
      big_idx = lchild;
      big_ent = h_qa;
    end
    r_big = r_ok && (h_qb[19:16] > big_ent[19:16]);
    if (r_big) begin
      big_idx = rchild;
      big_ent = h_qb;
    end
  end

  // writes: up_step moves parent down or parks cur; dn_step moves child up or parks cur
  always_comb begin
    h_we    = 1'b0;
    h_waddr = HAW'(idx - 1'b1);
    h_wdata = cur;
    if (cmd.up_step) begin
      h_we = 1'b1;
      if (!stat.up_done) begin
        h_wdata = h_qa;
      end
    end else if (cmd.dn_step) begin
      h_we = 1'b1;
      if (!stat.dn_done) begin
        h_wdata = big_ent;
      end
    end
  end

  assign stat.up_done    = (idx <= (HIW+1)'(1)) ||
                           !(cur[19:16] > h_qa[19:16]);
  assign stat.dn_done    = (big_idx == idx);
  assign stat.heap_full  = heap_count == HIW'(HEAP_DEPTH);
  assign stat.heap_empty = heap_count == '0;
  assign stat.fifo_full  = fifo_count == FCW'(FIFO_DEPTH);
  assign stat.fifo_empty = fifo_count == '0;

  tlpd_ram #(.WIDTH(HEW), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr_a(h_ra), .rdata_a(h_qa), .raddr_b(h_rb), .rdata_b(h_qb)
  );

  tlpd_ram #(.WIDTH(16), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .we(cmd.fifo_push), .waddr(fifo_tail), .wdata(req.payload_tag),
    .raddr_a(fifo_head), .rdata_a(f_qa), .raddr_b(fifo_head), .rdata_b(f_qb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_count <= '0;
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
    end else begin
      if (cmd.fifo_push) begin
        fifo_tail  <= (fifo_tail == FAW'(FIFO_DEPTH - 1)) ? '0 : fifo_tail + 1'b1;
        fifo_count <= fifo_count + 1'b1;
      end
      if (cmd.fifo_pop) begin
        fifo_head  <= (fifo_head == FAW'(FIFO_DEPTH - 1)) ? '0 : fifo_head + 1'b1;
        fifo_count <= fifo_count - 1'b1;
      end
      if (cmd.up_start) begin
        heap_count <= heap_count + 1'b1;
      end
      if (cmd.pop_root) begin
        heap_count <= heap_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_item;
      res <= '{status: ST_OK, source: SRC_NONE, out_urgency: '0, out_tag: '0};
    end
    if (cmd.set_full) begin
      res.status <= ST_FULL;
    end
    if (cmd.set_empty) begin
      res.status <= ST_EMPTY;
    end
    if (cmd.up_start) begin
      idx <= (HIW+1)'(heap_count) + 1'b1;
      cur <= {req.urgency, req.payload_tag};
    end
    if (cmd.up_step && !stat.up_done) begin
      idx <= parent;
    end
    if (cmd.fifo_pop) begin
      res.source      <= SRC_FIFO;
      res.out_urgency <= NORMAL_URGENCY;
      res.out_tag     <= f_qa;
    end
    if (cmd.pop_root) begin
      res.source      <= SRC_HEAP;
      res.out_urgency <= h_qa[19:16];
      res.out_tag     <= h_qa[15:0];
      cur             <= h_qb;
      idx             <= (HIW+1)'(1);
    end
    if (cmd.dn_step && !stat.dn_done) begin
      idx <= big_idx;
    end
  end

  logic unused_ok;
  assign unused_ok = cmd.fifo_rd ^ cmd.set_ok ^ (|f_qb);

endmodule

@@ hw/rtl/tlpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlpd_ctrl
// Request sequencer: decodes a request and steps the heap sift loops.
// ----------------------------------------------------------------------------
module tlpd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req,
  output logic                out_valid,
  input  logic                out_stall,
  input  tlpd_pkg::stat_t     stat,
  output tlpd_pkg::cmd_t      cmd
);
  import tlpd_pkg::*;

  state_t state, state_next;
  req_type_t rq;
  logic [1:0] rq_type;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rq_type <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        rq_type <= in_req;
      end
    end
  end
  assign rq = req_type_t'(rq_type);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_FIFO_RD;
      S_FIFO_RD: begin
        case (rq)
          REQ_NORMAL: state_next = S_DONE;
          REQ_URGENT: state_next = stat.heap_full ? S_DONE : S_UP_RD;
          REQ_TAKE: begin
            if (!stat.heap_empty)      state_next = S_POP_RD;
            else if (!stat.fifo_empty) state_next = S_FIFO_WAIT;
            else                       state_next = S_DONE;
          end
          default:    state_next = S_DONE;
        endcase
      end
      S_FIFO_WAIT: state_next = S_DONE;
      S_UP_RD:     state_next = S_UP_WAIT;
      S_UP_WAIT:   state_next = S_UP_CMP;
      S_UP_CMP:    state_next = stat.up_done ? S_DONE : S_UP_WAIT;
      S_POP_RD:    state_next = S_POP_WAIT;
      S_POP_WAIT:  state_next = S_POP_ROOT;
      S_POP_ROOT:  state_next = S_DN_RD;
      S_DN_RD:     state_next = S_DN_WAIT;
      S_DN_WAIT:   state_next = S_DN_CMP;
      S_DN_CMP:    state_next = stat.dn_done ? S_DONE : S_DN_RD;
      S_DONE:      if (!out_stall) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:      cmd.load_req = in_valid;
      S_FIFO_RD: begin
        case (rq)
          REQ_NORMAL: begin
            cmd.fifo_push = !stat.fifo_full;
            cmd.set_full  = stat.fifo_full;
          end
          REQ_URGENT: begin
            cmd.up_start = !stat.heap_full;
            cmd.set_full = stat.heap_full;
          end
          REQ_TAKE: begin
            cmd.set_empty = stat.heap_empty && stat.fifo_empty;
            cmd.fifo_rd   = stat.heap_empty && !stat.fifo_empty;
          end
          default:    cmd.set_ok = 1'b1;
        endcase
      end
      S_FIFO_WAIT: cmd.fifo_pop = 1'b1;
      S_UP_RD:     cmd.up_rd    = 1'b1;
      S_UP_WAIT:   cmd.up_rd    = 1'b1;
      S_UP_CMP:    cmd.up_step  = 1'b1;
      S_POP_RD:    cmd.pop_rd   = 1'b1;
      S_POP_WAIT:  cmd.pop_rd   = 1'b1;
      S_POP_ROOT:  cmd.pop_root = 1'b1;
      S_DN_RD:     cmd.dn_rd    = 1'b1;
      S_DN_WAIT:   cmd.dn_rd    = 1'b1;
      S_DN_CMP:    cmd.dn_step  = 1'b1;
      default:     cmd = '0;
    endcase
  end

  // no new request while a result is outstanding
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while result pending");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  // a push never happens on a full fifo
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.fifo_push |-> !stat.fifo_full) else $error("push into full fifo");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the two-level priority dispatcher against a behavioral heap/FIFO
// predictor. Directed cases cover the empty and full stores, low urgencies,
// equal keys and the reserved request code; random traffic follows with
// random idle gaps on the input side and, in most phases, on the output.
// ----------------------------------------------------------------------------
module testbench;
  import tlpd_pkg::*;

  localparam int HEAP_DEPTH = 64;
  localparam int FIFO_DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_item_t out_data;

  // predictor state, heap slots 1..HEAP_DEPTH
  logic [3:0]  heap_key_mdl [HEAP_DEPTH+1];
  logic [15:0] heap_tag_mdl [HEAP_DEPTH+1];
  int          heap_cnt_mdl;
  logic [15:0] fifo_tag_mdl [$];

  out_item_t   pending_results [$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          rx_idle_on = 1'b1;

  two_level_priority_dispatcher_top #(
    .HEAP_DEPTH(HEAP_DEPTH),
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [3:0]  k;
    logic [15:0] t;
    k = heap_key_mdl[a]; t = heap_tag_mdl[a];
    heap_key_mdl[a] = heap_key_mdl[b]; heap_tag_mdl[a] = heap_tag_mdl[b];
    heap_key_mdl[b] = k; heap_tag_mdl[b] = t;
  endfunction

  function automatic out_item_t dispatch_result(in_item_t rq);
    out_item_t res;
    int i, l, r, big;
    res = '0;
    res.status = ST_OK;
    res.source = SRC_NONE;
    case (req_type_t'(rq.req_type))
      REQ_NORMAL: begin
        if (fifo_tag_mdl.size() >= FIFO_DEPTH) res.status = ST_FULL;
        else fifo_tag_mdl.push_back(rq.payload_tag);
      end
      REQ_URGENT: begin
        if (heap_cnt_mdl >= HEAP_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          heap_cnt_mdl++;
          i = heap_cnt_mdl;
          heap_key_mdl[i] = rq.urgency;
          heap_tag_mdl[i] = rq.payload_tag;
          while (i > 1 && heap_key_mdl[i] > heap_key_mdl[i/2]) begin
            swap_slots(i, i/2);
            i = i / 2;
          end
        end
      end
      REQ_TAKE: begin
        if (heap_cnt_mdl > 0) begin
          res.source = SRC_HEAP;
          res.out_urgency = heap_key_mdl[1];
          res.out_tag = heap_tag_mdl[1];
          heap_key_mdl[1] = heap_key_mdl[heap_cnt_mdl];
          heap_tag_mdl[1] = heap_tag_mdl[heap_cnt_mdl];
          heap_cnt_mdl--;
          i = 1;
          forever begin
            l = 2 * i; r = 2 * i + 1; big = i;
            if (l <= heap_cnt_mdl && heap_key_mdl[l] > heap_key_mdl[big]) big = l;
            if (r <= heap_cnt_mdl && heap_key_mdl[r] > heap_key_mdl[big]) big = r;
            if (big == i) break;
            swap_slots(i, big);
            i = big;
          end
        end else if (fifo_tag_mdl.size() > 0) begin
          res.source = SRC_FIFO;
          res.out_urgency = NORMAL_URGENCY;
          res.out_tag = fifo_tag_mdl.pop_front();
        end else begin
          res.status = ST_EMPTY;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // one request, held until accepted; valid stays up into a back-to-back request
  task automatic send_request(req_type_t kind, logic [3:0] urg, logic [15:0] tag);
    in_item_t rq;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    rq.req_type = kind;
    rq.urgency = urg;
    rq.payload_tag = tag;
    in_data <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(dispatch_result(rq));
  endtask

  task automatic send_random(int urgent_pct, int take_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < urgent_pct)
      send_request(REQ_URGENT, 4'($urandom_range(0, 15)), 16'($urandom));
    else if (r < urgent_pct + take_pct)
      send_request(REQ_TAKE, 4'($urandom_range(0, 15)), 16'($urandom));
    else if (r < 98)
      send_request(REQ_NORMAL, 4'($urandom_range(0, 15)), 16'($urandom));
    else
      send_request(REQ_RSVD, 4'($urandom_range(0, 15)), 16'($urandom));
  endtask

  task automatic test_empty_and_edges();
    send_request(REQ_TAKE, 4'hf, 16'hffff);
    send_request(REQ_RSVD, 4'hf, 16'hffff);
    send_request(REQ_URGENT, 4'd0, 16'h0000);
    send_request(REQ_URGENT, 4'd1, 16'hffff);
    send_request(REQ_URGENT, 4'd15, 16'h5a5a);
    send_request(REQ_URGENT, 4'd15, 16'ha5a5);
    send_request(REQ_NORMAL, 4'd15, 16'h1234);
    send_request(REQ_NORMAL, 4'd0, 16'hffff);
    repeat (7) send_request(REQ_TAKE, 4'd0, 16'h0);
  endtask

  // fill both stores past full, then drain past empty
  task automatic test_full_stores();
    repeat (HEAP_DEPTH + 2)
      send_request(REQ_URGENT, 4'($urandom_range(0, 15)), 16'($urandom));
    repeat (FIFO_DEPTH + 2) send_request(REQ_NORMAL, 4'd0, 16'($urandom));
    repeat (HEAP_DEPTH + FIFO_DEPTH + 2) send_request(REQ_TAKE, 4'd0, 16'h0);
  endtask

  task automatic test_random_traffic();
    repeat (125) send_random(40, 35);
    rx_idle_on = 1'b0;
    repeat (100) send_random(35, 40);
    rx_idle_on = 1'b1;
    repeat (125) send_random(45, 15);   // drift toward full
    repeat (125) send_random(25, 60);   // drift toward empty
    repeat (100) send_random(35, 35);
  endtask

  // receiver: random stall while rx_idle_on is set; compares each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%t: unexpected result %h", $realtime, out_data);
          errors++;
        end else begin
          out_item_t exp_r;
          exp_r = pending_results.pop_front();
          if (out_data.status !== exp_r.status)
            $display("%t: status exp %0d got %0d", $realtime, exp_r.status, out_data.status);
          if (out_data.source !== exp_r.source)
            $display("%t: source exp %0d got %0d", $realtime, exp_r.source, out_data.source);
          if (out_data.out_urgency !== exp_r.out_urgency)
            $display("%t: urgency exp %0d got %0d", $realtime, exp_r.out_urgency,
                     out_data.out_urgency);
          if (out_data.out_tag !== exp_r.out_tag)
            $display("%t: tag exp %h got %h", $realtime, exp_r.out_tag, out_data.out_tag);
          if (out_data !== exp_r) errors++;
        end
      end
      out_stall <= rx_idle_on ? ($urandom_range(0, 99) < 30) : 1'b0;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    heap_cnt_mdl = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_edges();
    test_full_stores();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tlpd_pkg.sv
hw/rtl/tlpd_ram.sv
hw/rtl/tlpd_datapath.sv
hw/rtl/tlpd_ctrl.sv
hw/rtl/two_level_priority_dispatcher_top.sv
sim/testbench.sv
